FILE: src/s2d_pkg.sv
// ----------------------------------------------------------------------------
// s2d_pkg: shared types and constants for the integer to decimal converter
// Widths, character codes, the queue item and the back-end state encoding.
// ----------------------------------------------------------------------------
package s2d_pkg;

    localparam int VALUE_W     = 64;
    localparam int MAG_W       = 64;
    localparam int CHAR_W      = 8;
    localparam int NUM_DIGITS  = 19;
    localparam int BCD_W       = NUM_DIGITS * 4;
    localparam int NDIG_W      = $clog2(NUM_DIGITS + 1);
    localparam int CNT_W       = $clog2(MAG_W);
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CHAR_W-1:0] DIGIT_BASE = 8'd48;
    localparam logic [CHAR_W-1:0] MINUS_CHAR = 8'h2d;

    // classified request: sign and unsigned magnitude
    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
    } t_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_SIGN,
        ST_EMIT
    } t_state;

endpackage

FILE: src/s2d_ifs.sv
// ----------------------------------------------------------------------------
// s2d interfaces: valid/ready channels of the converter
// Input channel carries the signed value, output channel one character.
// ----------------------------------------------------------------------------
interface s2d_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [s2d_pkg::VALUE_W-1:0]  value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface s2d_out_if;
    logic                         valid;
    logic                         ready;
    logic [s2d_pkg::CHAR_W-1:0]   character;
    logic                         last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface

FILE: src/signed_int_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii: signed 64-bit integer to decimal ASCII text
// Top level wiring front end, request queue and conversion back end.
// ----------------------------------------------------------------------------
// Each request is one signed 64-bit value; the block answers with its decimal
// text, one ASCII character per output beat, most significant digit first, a
// leading '-' for negative values and last set on the final character. Zero
// gives a single '0' and the most negative value converts exactly. The front
// end classifies sign and magnitude and pushes into a short queue, so a new
// request is taken while the back end still works on the previous one. The
// back end handles one request at a time: it takes the request from the
// queue, runs the shift-add-3 loop over every magnitude bit, drops leading
// zero digits in the skip state, emits the minus sign when negative, then
// sends the digits into a registered output stage, holding while the output
// is stalled. The shift-add-3 loop takes most of a request's time. No state
// survives from one request to the next.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii #(
    parameter int QUEUE_DEPTH = s2d_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    s2d_in_if.sink      i_in,
    s2d_out_if.source   o_out
);

    // front to queue
    logic           w_push_valid;
    logic           w_push_ready;
    s2d_pkg::t_item w_push_item;

    // queue to back
    logic           w_pop_valid;
    logic           w_pop_ready;
    s2d_pkg::t_item w_pop_item;

    // sign split and two's complement magnitude
    s2d_front u_front (
        .i_in         (i_in),
        .o_push_valid (w_push_valid),
        .o_push_item  (w_push_item),
        .i_push_ready (w_push_ready)
    );

    // decouples intake from the long conversion
    s2d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .i_push_item  (w_push_item),
        .o_push_ready (w_push_ready),
        .o_pop_valid  (w_pop_valid),
        .o_pop_item   (w_pop_item),
        .i_pop_ready  (w_pop_ready)
    );

    // bcd conversion and character stream
    s2d_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (w_pop_valid),
        .i_pop_item  (w_pop_item),
        .o_pop_ready (w_pop_ready),
        .o_out       (o_out)
    );

endmodule

FILE: src/s2d_front.sv
// ----------------------------------------------------------------------------
// s2d_front: request intake and sign classification
// Splits the two's complement value into sign and unsigned magnitude.
// ----------------------------------------------------------------------------
module s2d_front (
    s2d_in_if.sink          i_in,
    output logic            o_push_valid,
    output s2d_pkg::t_item  o_push_item,
    input  logic            i_push_ready
);

    logic [s2d_pkg::VALUE_W-1:0] w_raw;

    assign w_raw        = i_in.value;
    assign i_in.ready   = i_push_ready;
    assign o_push_valid = i_in.valid;

    // negate as unsigned so the most negative value maps to 2^63
    always_comb begin
        o_push_item.neg = w_raw[s2d_pkg::VALUE_W-1];
        if (w_raw[s2d_pkg::VALUE_W-1]) begin
            o_push_item.mag = s2d_pkg::MAG_W'(~w_raw + 1'b1);
        end else begin
            o_push_item.mag = s2d_pkg::MAG_W'(w_raw);
        end
    end

endmodule

FILE: src/s2d_queue.sv
// ----------------------------------------------------------------------------
// s2d_queue: short request queue between front and back
// Circular buffer with read/write pointers and an occupancy count.
// ----------------------------------------------------------------------------
module s2d_queue #(
    parameter int DEPTH = s2d_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_valid,
    input  s2d_pkg::t_item  i_push_item,
    output logic            o_push_ready,
    output logic            o_pop_valid,
    output s2d_pkg::t_item  o_pop_item,
    input  logic            i_pop_ready
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    s2d_pkg::t_item r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_push, w_pop;

    assign o_push_ready = (r_count != CNT_W'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_item   = r_mem[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

endmodule

FILE: src/s2d_back.sv
// ----------------------------------------------------------------------------
// s2d_back: binary to BCD conversion and character emission
// Shift-add-3, leading zero skip, then one char per cycle when not stalled.
// ----------------------------------------------------------------------------
module s2d_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_pop_valid,
    input  s2d_pkg::t_item  i_pop_item,
    output logic            o_pop_ready,
    s2d_out_if.source       o_out
);

    localparam int BCD_W  = s2d_pkg::BCD_W;
    localparam int MAG_W  = s2d_pkg::MAG_W;
    localparam int CNT_W  = s2d_pkg::CNT_W;
    localparam int NDIG_W = s2d_pkg::NDIG_W;
    localparam int CHAR_W = s2d_pkg::CHAR_W;

    s2d_pkg::t_state r_state, n_state;

    logic [BCD_W-1:0]  r_bcd, n_bcd;
    logic [MAG_W-1:0]  r_mag, n_mag;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [NDIG_W-1:0] r_ndig, n_ndig;
    logic              r_neg, n_neg;
    logic [CHAR_W-1:0] r_char, n_char;
    logic              r_last, n_last;
    logic              r_ovalid, n_ovalid;

    logic              w_slot_free;
    logic              w_top_zero;
    logic [BCD_W-1:0]  w_adj;

    // add 3 to every digit of 5 or more
    function automatic logic [BCD_W-1:0] bcd_adjust(input logic [BCD_W-1:0] b);
        logic [BCD_W-1:0] res;
        res = b;
        for (int d = 0; d < s2d_pkg::NUM_DIGITS; d++) begin
            if (b[d*4 +: 4] >= 4'd5) begin
                res[d*4 +: 4] = b[d*4 +: 4] + 4'd3;
            end
        end
        return res;
    endfunction

    assign w_slot_free = !r_ovalid || o_out.ready;
    assign w_top_zero  = (r_bcd[BCD_W-1 -: 4] == 4'd0);
    assign w_adj       = bcd_adjust(r_bcd);

    assign o_out.valid     = r_ovalid;
    assign o_out.character = r_char;
    assign o_out.last      = r_last;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            s2d_pkg::ST_IDLE: begin
                if (i_pop_valid) n_state = s2d_pkg::ST_CONV;
            end
            s2d_pkg::ST_CONV: begin
                if (r_cnt == '0) n_state = s2d_pkg::ST_SKIP;
            end
            s2d_pkg::ST_SKIP: begin
                if (!(w_top_zero && r_ndig != NDIG_W'(1))) begin
                    n_state = r_neg ? s2d_pkg::ST_SIGN : s2d_pkg::ST_EMIT;
                end
            end
            s2d_pkg::ST_SIGN: begin
                if (w_slot_free) n_state = s2d_pkg::ST_EMIT;
            end
            s2d_pkg::ST_EMIT: begin
                if (w_slot_free && r_ndig == NDIG_W'(1)) n_state = s2d_pkg::ST_IDLE;
            end
            default: n_state = s2d_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        o_pop_ready = 1'b0;
        n_bcd       = r_bcd;
        n_mag       = r_mag;
        n_cnt       = r_cnt;
        n_ndig      = r_ndig;
        n_neg       = r_neg;
        n_char      = r_char;
        n_last      = r_last;
        n_ovalid    = r_ovalid && !o_out.ready;
        unique case (r_state)
            s2d_pkg::ST_IDLE: begin
                o_pop_ready = 1'b1;
                n_bcd       = '0;
                n_mag       = i_pop_item.mag;
                n_neg       = i_pop_item.neg;
                n_cnt       = CNT_W'(MAG_W - 1);
            end
            s2d_pkg::ST_CONV: begin
                n_bcd  = {w_adj[BCD_W-2:0], r_mag[MAG_W-1]};
                n_mag  = {r_mag[MAG_W-2:0], 1'b0};
                n_cnt  = r_cnt - 1'b1;
                n_ndig = NDIG_W'(s2d_pkg::NUM_DIGITS);
            end
            s2d_pkg::ST_SKIP: begin
                if (w_top_zero && r_ndig != NDIG_W'(1)) begin
                    n_bcd  = {r_bcd[BCD_W-5:0], 4'd0};
                    n_ndig = r_ndig - 1'b1;
                end
            end
            s2d_pkg::ST_SIGN: begin
                if (w_slot_free) begin
                    n_char   = s2d_pkg::MINUS_CHAR;
                    n_last   = 1'b0;
                    n_ovalid = 1'b1;
                end
            end
            s2d_pkg::ST_EMIT: begin
                if (w_slot_free) begin
                    n_char   = s2d_pkg::DIGIT_BASE + CHAR_W'(r_bcd[BCD_W-1 -: 4]);
                    n_last   = (r_ndig == NDIG_W'(1));
                    n_ovalid = 1'b1;
                    n_bcd    = {r_bcd[BCD_W-5:0], 4'd0};
                    n_ndig   = r_ndig - 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= s2d_pkg::ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bcd  <= n_bcd;
        r_mag  <= n_mag;
        r_cnt  <= n_cnt;
        r_ndig <= n_ndig;
        r_neg  <= n_neg;
        r_char <= n_char;
        r_last <= n_last;
    end

endmodule

FILE: src/s2d_checker.sv
// ----------------------------------------------------------------------------
// s2d_checker: port-level assertions for the converter
// Checks output stream contents and stall behavior, bound to the top level.
// ----------------------------------------------------------------------------
module s2d_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [s2d_pkg::CHAR_W-1:0]  i_out_char,
    input logic                        i_out_last
);

    // stalled character holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_char) && $stable(i_out_last))
        else $error("output changed while stalled");

    // only minus or a digit
    a_char_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_char == s2d_pkg::MINUS_CHAR) ||
            ((i_out_char >= s2d_pkg::DIGIT_BASE) &&
             (i_out_char <= s2d_pkg::DIGIT_BASE + 8'd9)))
        else $error("character outside minus and digits");

    // sign never ends a number
    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_char == s2d_pkg::MINUS_CHAR) |-> !i_out_last)
        else $error("minus flagged as last");

    // after an accepted minus the next valid character is not a second minus
    a_minus_then_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && (i_out_char == s2d_pkg::MINUS_CHAR) |=>
            !(i_out_valid && (i_out_char == s2d_pkg::MINUS_CHAR)))
        else $error("two minus signs in a row");

    // reset empties the output stage
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

endmodule

bind signed_int_to_decimal_ascii s2d_checker u_s2d_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_char  (o_out.character),
    .i_out_last  (o_out.last)
);
